// ----- rtl/core/btmx_pkg.sv -----
// ----------------------------------------------------------------------------
// btmx_pkg
// shared constants for the binary trie minimum xor multiset unit
// ----------------------------------------------------------------------------
package btmx_pkg;

	localparam int KEY_BITS   = 16;
	localparam int NODE_POOL  = 4096;
	localparam int COUNT_BITS = 16;

	localparam int TYPE_W  = 2;
	localparam int KEY_W   = 16;
	localparam int XOR_W   = 16;
	localparam int MCNT_W  = 16;
	localparam int STAT_W  = 2;

	localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_DELETE = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_QUERY  = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd1;
	localparam logic [STAT_W-1:0] STAT_POOL   = 2'd2;
	localparam logic [STAT_W-1:0] STAT_COUNT  = 2'd3;

endpackage

// ----- rtl/core/btmx_ram.sv -----
// ----------------------------------------------------------------------------
// btmx_ram
// simple dual port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module btmx_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/binary_trie_min_xor_multiset_unit.sv -----
// ----------------------------------------------------------------------------
// binary_trie_min_xor_multiset_unit
// multiset of keys kept as a binary trie in a node ram, insert, delete and
// minimum xor query, one request at a time
// ----------------------------------------------------------------------------
// One request is handled at a time; a finished word waits in an output
// register while the next request is taken. The trie walk runs from the top
// key bit down, reading nodes from the node ram through its registered read
// port. Insert and delete walk the path twice (a check pass, then an update
// pass that writes each node back). A query walks once and may read both
// children of a level. A full count on insert or a query on an empty set is
// answered without a walk. The root node sits in registers; no clearing
// pass is needed after reset.
module binary_trie_min_xor_multiset_unit #(
	parameter int KEY_BITS   = btmx_pkg::KEY_BITS,
	parameter int NODE_POOL  = btmx_pkg::NODE_POOL,
	parameter int COUNT_BITS = btmx_pkg::COUNT_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [btmx_pkg::TYPE_W-1:0] req_type,
	input  logic [btmx_pkg::KEY_W-1:0]  key,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [btmx_pkg::XOR_W-1:0]  min_xor,
	output logic [btmx_pkg::MCNT_W-1:0] match_count,
	output logic [btmx_pkg::STAT_W-1:0] status
);

	localparam int IDX_BITS = $clog2(NODE_POOL);
	localparam int NXT_BITS = $clog2(NODE_POOL + 1);
	localparam int LVL_BITS = $clog2(KEY_BITS + 1);
	localparam int KB_BITS  = $clog2(KEY_BITS);
	localparam int ENT_W    = 2 * IDX_BITS + COUNT_BITS;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_STEP = 3'd1;
	localparam logic [2:0] S_LOAD = 3'd2;
	localparam logic [2:0] S_QCHK = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0]                  state_q;
	logic [btmx_pkg::TYPE_W-1:0] op_q;
	logic [KEY_BITS-1:0]         key_q;
	logic                        pass_q;
	logic [LVL_BITS-1:0]         rem_q;
	logic [KEY_BITS-1:0]         acc_q;
	logic [IDX_BITS-1:0]         cur_idx_q, cur_lo_q, cur_hi_q, rd_addr_q;
	logic [COUNT_BITS-1:0]       cur_cnt_q;
	logic [IDX_BITS-1:0]         root_lo_q, root_hi_q;
	logic [COUNT_BITS-1:0]       root_cnt_q;
	logic [NXT_BITS-1:0]         next_q;
	logic [KEY_BITS-1:0]         res_mx_q;
	logic [COUNT_BITS-1:0]       res_mc_q;
	logic [btmx_pkg::STAT_W-1:0] res_st_q;
	logic                        out_valid_q;
	logic [KEY_BITS-1:0]         out_mx_q;
	logic [COUNT_BITS-1:0]       out_mc_q;
	logic [btmx_pkg::STAT_W-1:0] out_st_q;

	logic [31:0]           key_ext, mx_ext, mc_ext;
	logic [KB_BITS-1:0]    b_idx;
	logic                  side;
	logic [IDX_BITS-1:0]   child, alt, rd_addr, new_idx;
	logic [ENT_W-1:0]      rdata, wdata;
	logic [IDX_BITS-1:0]   rd_lo, rd_hi;
	logic [COUNT_BITS-1:0] rd_cnt;
	logic                  wr_en;
	logic [IDX_BITS-1:0]   wr_lo, wr_hi;
	logic [COUNT_BITS-1:0] wr_cnt;
	logic                  pool_short;
	logic [NXT_BITS:0]     pool_sum;

	assign key_ext = 32'(key);
	assign b_idx   = KB_BITS'(rem_q - LVL_BITS'(1));
	assign side    = key_q[b_idx];
	assign child   = side ? cur_hi_q : cur_lo_q;
	assign alt     = side ? cur_lo_q : cur_hi_q;
	assign rd_addr = (state_q == S_QCHK || child == '0) ? alt : child;
	assign new_idx = next_q[IDX_BITS-1:0];
	assign rd_lo   = rdata[ENT_W-1 -: IDX_BITS];
	assign rd_hi   = rdata[COUNT_BITS +: IDX_BITS];
	assign rd_cnt  = rdata[COUNT_BITS-1:0];
	assign pool_sum   = (NXT_BITS+1)'(next_q) + (NXT_BITS+1)'(rem_q);
	assign pool_short = pool_sum > (NXT_BITS+1)'(NODE_POOL);

	// node write-back during the update pass
	always_comb begin
		wr_en  = 1'b0;
		wr_lo  = cur_lo_q;
		wr_hi  = cur_hi_q;
		wr_cnt = cur_cnt_q;
		if (state_q == S_STEP && pass_q) begin
			wr_en = 1'b1;
			if (op_q == btmx_pkg::REQ_INSERT) begin
				wr_cnt = cur_cnt_q + COUNT_BITS'(1);
				if (rem_q != '0 && child == '0) begin
					if (side) begin
						wr_hi = new_idx;
					end else begin
						wr_lo = new_idx;
					end
				end
			end else begin
				wr_cnt = cur_cnt_q - COUNT_BITS'(1);
			end
		end
	end

	assign wdata = {wr_lo, wr_hi, wr_cnt};

	btmx_ram #(
		.WIDTH(ENT_W),
		.DEPTH(NODE_POOL)
	) u_node_ram (
		.clk  (clk),
		.we   (wr_en && cur_idx_q != '0),
		.waddr(cur_idx_q),
		.wdata(wdata),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			root_lo_q   <= '0;
			root_hi_q   <= '0;
			root_cnt_q  <= '0;
			next_q      <= NXT_BITS'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			if (wr_en && cur_idx_q == '0) begin
				root_lo_q  <= wr_lo;
				root_hi_q  <= wr_hi;
				root_cnt_q <= wr_cnt;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q      <= req_type;
						key_q     <= key_ext[KEY_BITS-1:0];
						acc_q     <= '0;
						pass_q    <= 1'b0;
						rem_q     <= LVL_BITS'(KEY_BITS);
						cur_idx_q <= '0;
						cur_lo_q  <= root_lo_q;
						cur_hi_q  <= root_hi_q;
						cur_cnt_q <= root_cnt_q;
						res_mx_q  <= '0;
						res_mc_q  <= '0;
						case (req_type)
							btmx_pkg::REQ_INSERT: begin
								if (root_cnt_q == '1) begin
									res_st_q <= btmx_pkg::STAT_COUNT;
									state_q  <= S_FIN;
								end else begin
									res_st_q <= btmx_pkg::STAT_OK;
									state_q  <= S_STEP;
								end
							end
							btmx_pkg::REQ_DELETE: begin
								res_st_q <= btmx_pkg::STAT_OK;
								state_q  <= S_STEP;
							end
							btmx_pkg::REQ_QUERY: begin
								if (root_cnt_q == '0) begin
									res_st_q <= btmx_pkg::STAT_ABSENT;
									state_q  <= S_FIN;
								end else begin
									res_st_q <= btmx_pkg::STAT_OK;
									state_q  <= S_STEP;
								end
							end
							default: begin
								res_st_q <= btmx_pkg::STAT_OK;
								state_q  <= S_FIN;
							end
						endcase
					end
				end
				S_STEP: begin
					rd_addr_q <= rd_addr;
					if (op_q == btmx_pkg::REQ_QUERY) begin
						if (rem_q == '0) begin
							res_mx_q <= acc_q;
							res_mc_q <= cur_cnt_q;
							state_q  <= S_FIN;
						end else if (child != '0) begin
							state_q <= S_QCHK;
						end else if (alt != '0) begin
							acc_q[b_idx] <= 1'b1;
							state_q      <= S_QCHK;
						end else begin
							res_st_q <= btmx_pkg::STAT_ABSENT;
							state_q  <= S_FIN;
						end
					end else if (!pass_q) begin
						// check pass
						if (op_q == btmx_pkg::REQ_DELETE && cur_cnt_q == '0) begin
							res_st_q <= btmx_pkg::STAT_ABSENT;
							state_q  <= S_FIN;
						end else if (rem_q == '0 ||
							(op_q == btmx_pkg::REQ_INSERT && child == '0)) begin
							if (op_q == btmx_pkg::REQ_INSERT && pool_short) begin
								res_st_q <= btmx_pkg::STAT_POOL;
								state_q  <= S_FIN;
							end else begin
								pass_q    <= 1'b1;
								rem_q     <= LVL_BITS'(KEY_BITS);
								cur_idx_q <= '0;
								cur_lo_q  <= root_lo_q;
								cur_hi_q  <= root_hi_q;
								cur_cnt_q <= root_cnt_q;
							end
						end else if (child == '0) begin
							res_st_q <= btmx_pkg::STAT_ABSENT;
							state_q  <= S_FIN;
						end else begin
							state_q <= S_LOAD;
						end
					end else begin
						// update pass
						if (rem_q == '0) begin
							state_q <= S_FIN;
						end else if (op_q == btmx_pkg::REQ_INSERT && child == '0) begin
							next_q    <= next_q + NXT_BITS'(1);
							cur_idx_q <= new_idx;
							cur_lo_q  <= '0;
							cur_hi_q  <= '0;
							cur_cnt_q <= '0;
							rem_q     <= rem_q - LVL_BITS'(1);
						end else begin
							state_q <= S_LOAD;
						end
					end
				end
				S_LOAD: begin
					cur_idx_q <= rd_addr_q;
					cur_lo_q  <= rd_lo;
					cur_hi_q  <= rd_hi;
					cur_cnt_q <= rd_cnt;
					rem_q     <= rem_q - LVL_BITS'(1);
					state_q   <= S_STEP;
				end
				S_QCHK: begin
					if (rd_cnt != '0) begin
						cur_idx_q <= rd_addr_q;
						cur_lo_q  <= rd_lo;
						cur_hi_q  <= rd_hi;
						cur_cnt_q <= rd_cnt;
						rem_q     <= rem_q - LVL_BITS'(1);
						state_q   <= S_STEP;
					end else if (rd_addr_q != alt && alt != '0) begin
						rd_addr_q    <= alt;
						acc_q[b_idx] <= 1'b1;
						state_q      <= S_LOAD;
					end else begin
						res_st_q <= btmx_pkg::STAT_ABSENT;
						res_mx_q <= '0;
						state_q  <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (state_q == S_FIN && (!out_valid_q || out_ready)) begin
			out_mx_q <= res_mx_q;
			out_mc_q <= res_mc_q;
			out_st_q <= res_st_q;
		end
	end

	assign mx_ext      = 32'(out_mx_q);
	assign mc_ext      = 32'(out_mc_q);
	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign min_xor     = mx_ext[btmx_pkg::XOR_W-1:0];
	assign match_count = mc_ext[btmx_pkg::MCNT_W-1:0];
	assign status      = out_st_q;

endmodule
